### hdl/stereo_biquad_lowpass_assert.svh
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass_assert
// assertion macros for the stereo biquad low-pass block
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_LOWPASS_ASSERT_SVH
`define STEREO_BIQUAD_LOWPASS_ASSERT_SVH
`ifndef SYNTHESIS
`define SBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// shared constants for the stereo biquad low-pass block
// ----------------------------------------------------------------------------
package sbq_pkg;

    // guard bits on the delay state above the sample width
    localparam int GUARD_BITS = 8;

    // configuration register indexes
    localparam int          CFG_ADDR_W = 2;
    localparam logic [1:0]  REG_B0     = 2'd0;
    localparam logic [1:0]  REG_A1     = 2'd1;
    localparam logic [1:0]  REG_A2     = 2'd2;
    localparam logic [1:0]  REG_BYPASS = 2'd3;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

endpackage

### hdl/stereo_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass
// two-channel direct form II biquad low-pass with one shared multiplier
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: sample_in (SAMPLE_WIDTH); tuser: channel_in
//  m_axis    out        tdata: sample_out (SAMPLE_WIDTH); tuser: channel_out
//  cfg       in         we, addr (register index), data (COEF_WIDTH)
//
//  filtered item: the single multiplier is used three times in turn
//  (a1*w1, a2*w2, b0*sum), with rounding, saturation and the numerator sum
//  steps between; a bypassed item goes straight to the last step
//  a new item is taken while the previous result waits in the output
//  register; the sequencer holds in its last step if that register is full
//  i_rst_n is synchronous, active low: delays and coefficients clear, bypass on
// ----------------------------------------------------------------------------
`include "stereo_biquad_lowpass_assert.svh"

module stereo_biquad_lowpass #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,  // sample_in
    input  logic                                  i_s_axis_tuser,  // channel_in
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,  // sample_out
    output logic                                  o_m_axis_tuser,  // channel_out
    // configuration writes
    input  logic                                  i_cfg_we,
    input  sbq_pkg::t_cfg_addr                    i_cfg_addr,
    input  logic [COEF_WIDTH-1:0]                 i_cfg_data
);

    // widths
    localparam int DW   = ((SAMPLE_WIDTH + 7) / 8) * 8;     // padded tdata
    localparam int STW  = SAMPLE_WIDTH + sbq_pkg::GUARD_BITS; // delay state
    localparam int SUMW = STW + 2;                           // w + 2*w1 + w2
    localparam int PW   = COEF_WIDTH + SUMW;                 // product
    localparam int FRAC = COEF_WIDTH - 2;                    // coef fraction
    localparam int AW   = PW - FRAC;                         // rounded product

    localparam logic signed [PW-1:0] HALF   = PW'(1) << (FRAC - 1);
    localparam logic signed [AW-1:0] ST_MAX = {{(AW-STW+1){1'b0}}, {(STW-1){1'b1}}};
    localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [AW-1:0] Y_MAX  =
        {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] Y_MIN  = ~Y_MAX;

    // sequencer steps
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;   // a1*w1
    localparam logic [2:0] S_M2   = 3'd2;   // a2*w2, x - round(a1*w1)
    localparam logic [2:0] S_W    = 3'd3;   // w = sat(acc - round(a2*w2))
    localparam logic [2:0] S_S    = 3'd4;   // w + 2*w1 + w2
    localparam logic [2:0] S_M3   = 3'd5;   // b0*sum
    localparam logic [2:0] S_Y    = 3'd6;   // round, saturate, write result

    // product rounded to nearest, ties away from zero
    function automatic logic signed [AW-1:0] f_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (p[PW-1] ? (HALF - PW'(1)) : HALF);
        return AW'(t >>> FRAC);
    endfunction

    function automatic logic signed [STW-1:0] f_sat_st(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
        return c[STW-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] f_sat_y(
        input logic signed [AW-1:0] v
    );
        logic signed [AW-1:0] c;
        c = (v > Y_MAX) ? Y_MAX : ((v < Y_MIN) ? Y_MIN : v);
        return c[SAMPLE_WIDTH-1:0];
    endfunction

    // configuration
    logic signed [COEF_WIDTH-1:0] r_b0, r_a1, r_a2;
    logic                         r_bypass;

    // per-channel delay pair
    logic signed [STW-1:0] r_w1 [2];
    logic signed [STW-1:0] r_w2 [2];

    // item in flight
    logic [2:0]                     r_state, n_state;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_ch;
    logic                           r_byp;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_acc;
    logic signed [STW-1:0]          r_w;
    logic signed [SUMW-1:0]         r_sum;

    // output register
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_out_ch;

    logic                           s_accept;
    logic                           adv;
    logic                           coef_wr;
    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [SUMW-1:0]         mul_b;
    logic signed [PW-1:0]           mul_p;
    logic signed [STW-1:0]          cur_w1, cur_w2;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    // last step may only go ahead once the output register is free
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign coef_wr         = i_cfg_we && (i_cfg_addr inside {sbq_pkg::REG_B0,
                             sbq_pkg::REG_A1, sbq_pkg::REG_A2});

    assign cur_w1 = r_w1[r_ch];
    assign cur_w2 = r_w2[r_ch];

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_M1: begin
                mul_a = r_a1;
                mul_b = SUMW'(cur_w1);
            end
            S_M2: begin
                mul_a = r_a2;
                mul_b = SUMW'(cur_w2);
            end
            default: begin
                mul_a = r_b0;
                mul_b = r_sum;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_accept) begin
                n_state = r_bypass ? S_Y : S_M1;
            end
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_W;
            S_W:     n_state = S_S;
            S_S:     n_state = S_M3;
            S_M3:    n_state = S_Y;
            S_Y:     if (adv) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sbq_pkg::REG_B0:     r_b0     <= i_cfg_data;
                sbq_pkg::REG_A1:     r_a1     <= i_cfg_data;
                sbq_pkg::REG_A2:     r_a2     <= i_cfg_data;
                sbq_pkg::REG_BYPASS: r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // delay state: cleared on reset and on any coefficient write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || coef_wr) begin
            r_w1[0] <= '0;
            r_w1[1] <= '0;
            r_w2[0] <= '0;
            r_w2[1] <= '0;
        end else if (r_state == S_Y && adv && !r_byp) begin
            r_w2[r_ch] <= cur_w1;
            r_w1[r_ch] <= r_w;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x   <= SAMPLE_WIDTH'(i_s_axis_tdata);
            r_ch  <= i_s_axis_tuser;
            r_byp <= r_bypass;
        end
        if (r_state inside {S_M1, S_M2, S_M3}) begin
            r_prod <= mul_p;
        end
        if (r_state == S_M2) begin
            r_acc <= AW'(r_x) - f_round(r_prod);
        end
        if (r_state == S_W) begin
            r_w <= f_sat_st(r_acc - f_round(r_prod));
        end
        if (r_state == S_S) begin
            r_sum <= SUMW'(r_w) + (SUMW'(cur_w1) <<< 1) + SUMW'(cur_w2);
        end
        if (r_state == S_Y && adv) begin
            r_y      <= r_byp ? r_x : f_sat_y(f_round(r_prod));
            r_out_ch <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_Y && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DW'($unsigned(r_y));
    assign o_m_axis_tuser  = r_out_ch;

    // checks
    `SBQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_accept, !o_s_axis_tready, "block still ready right after taking an item")
    `SBQ_ASSERT_NEXT(a_hold_full_output, i_clk, i_rst_n, r_state == S_Y && r_out_valid && !i_m_axis_tready, r_state == S_Y, "last step left while the output register was still full")
    `SBQ_ASSERT_IMPLY(a_result_from_last_step, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(r_state) == S_Y, "result shown without passing the last step")
    `SBQ_ASSERT_NEXT(a_delay_quiet, i_clk, i_rst_n, r_state != S_Y && !i_cfg_we, $stable(r_w1[0]) && $stable(r_w1[1]) && $stable(r_w2[0]) && $stable(r_w2[1]), "delay state changed outside the write step")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo biquad low-pass filter: a directed table
// of corner samples and register writes, then randomised coefficient phases
// with random idling on both streams, scored against typed-in results or an in-bench model
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 24;
    localparam int STATE_W     = SAMPLE_W + sbq_pkg::GUARD_BITS;
    localparam int COEF_FRAC   = COEF_W - 2;
    localparam int TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
    localparam int NUM_PHASES  = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_ROWS    = 35;

    localparam logic [SAMPLE_W-1:0] CORNER_VALUES [5] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF
    };

    // a gentle low-pass: a1 = -1.6, a2 = 0.64, b0 = (1 + a1 + a2) / 4
    localparam logic [COEF_W-1:0] LP_B0 = 24'h00A3D7;
    localparam logic [COEF_W-1:0] LP_A1 = 24'h99999A;
    localparam logic [COEF_W-1:0] LP_A2 = 24'h28F5C3;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        sbq_pkg::t_cfg_addr  addr;
        logic                ch;
        logic [SAMPLE_W-1:0] value;   // sample for an item, data for a write
        logic                known;   // result typed in below
        logic [SAMPLE_W-1:0] want;
    } t_stim_row;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
    } t_result;

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    t_stim_row directed_rows [NUM_ROWS] = '{
        // out of reset bypass is on: samples come back unchanged
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h800000, 1'b1, 24'h800000},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h000000, 1'b1, 24'h000000},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        // plain low-pass, impulse response on both channels
        '{ROW_WRITE, sbq_pkg::REG_B0,     1'b0, LP_B0,      1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A1,     1'b0, LP_A1,      1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A2,     1'b0, LP_A2,      1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_BYPASS, 1'b0, 24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h800000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h000000, 1'b0, 24'h0},
        // bypass on and off again keeps the delay state; upper data bits ignored
        '{ROW_WRITE, sbq_pkg::REG_BYPASS, 1'b0, 24'hFFFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h123456, 1'b1, 24'h123456},
        '{ROW_WRITE, sbq_pkg::REG_BYPASS, 1'b0, 24'hFFFFFE, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h000000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h000000, 1'b0, 24'h0},
        // extreme coefficients drive both w and y into saturation
        '{ROW_WRITE, sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A1,     1'b0, 24'h800000, 1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A2,     1'b0, 24'h800000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h800000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h800000, 1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_B0,     1'b0, 24'h800000, 1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A1,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_WRITE, sbq_pkg::REG_A2,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b0, 24'h800000, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_ITEM,  sbq_pkg::REG_B0,     1'b1, 24'h7FFFFF, 1'b0, 24'h0}
    };

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                i_s_axis_tuser  = 1'b0;
    logic                i_m_axis_tready = 1'b0;
    logic                i_cfg_we        = 1'b0;
    sbq_pkg::t_cfg_addr  i_cfg_addr      = sbq_pkg::REG_B0;
    logic [COEF_W-1:0]   i_cfg_data      = '0;

    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [TDATA_W-1:0]  o_m_axis_tdata;
    logic                o_m_axis_tuser;

    always #5 i_clk = ~i_clk;

    stereo_biquad_lowpass #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .COEF_WIDTH   (COEF_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // sample_in
        .i_s_axis_tuser  (i_s_axis_tuser),   // channel_in
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // sample_out
        .o_m_axis_tuser  (o_m_axis_tuser),   // channel_out
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // bench-side filter model: coefficients and per-channel delay pair
    // ------------------------------------------------------------------
    longint  coef_b0 = 0;
    longint  coef_a1 = 0;
    longint  coef_a2 = 0;
    bit      bypass_on = 1'b1;
    longint  tap_w1 [2] = '{0, 0};
    longint  tap_w2 [2] = '{0, 0};

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;

    // idling controls shared between the stimulus and the result sink
    bit      quiet_tx    = 1'b0;
    bit      quiet_rx    = 1'b0;
    int      rx_hold_len = 0;

    // coefficient product in Q2.22, rounded half away from zero
    function automatic longint scale_q22(input longint coef, input longint val);
        logic            neg;
        longint unsigned mag_c;
        longint unsigned mag_v;
        longint unsigned prod;
        neg   = (coef < 0) != (val < 0);
        mag_c = (coef < 0) ? -coef : coef;
        mag_v = (val < 0) ? -val : val;
        prod  = (mag_c * mag_v + (64'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint clamp(input longint v, input int width);
        longint hi;
        longint lo;
        hi = (longint'(1) << (width - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one of the corner samples, picked at random
    function automatic logic [SAMPLE_W-1:0] corner_pick();
        logic [2:0] idx;
        idx = 3'($urandom_range(0, 4));
        return CORNER_VALUES[idx];
    endfunction

    // one sample through the filter, advancing that channel's delay pair
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x,
                                                          input logic ch);
        longint xv;
        longint w;
        longint y;
        if (bypass_on) return x;
        xv = longint'($signed(x));
        w  = xv - scale_q22(coef_a1, tap_w1[ch]) - scale_q22(coef_a2, tap_w2[ch]);
        w  = clamp(w, STATE_W);
        y  = clamp(scale_q22(coef_b0, w + 2 * tap_w1[ch] + tap_w2[ch]), SAMPLE_W);
        tap_w2[ch] = tap_w1[ch];
        tap_w1[ch] = w;
        return y[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %0d at cycle %0d: %s got %h want %h",
                 mismatch_count, cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // register write: only once every pending result has been taken
    // ------------------------------------------------------------------
    task automatic write_reg(input sbq_pkg::t_cfg_addr idx, input logic [COEF_W-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let the sequencer fall back to idle
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            sbq_pkg::REG_B0: coef_b0 = longint'($signed(val));
            sbq_pkg::REG_A1: coef_a1 = longint'($signed(val));
            sbq_pkg::REG_A2: coef_a2 = longint'($signed(val));
            default: bypass_on = val[0];
        endcase
        // any coefficient write clears both channels' delays
        if (idx != sbq_pkg::REG_BYPASS) begin
            tap_w1 = '{0, 0};
            tap_w2 = '{0, 0};
        end
    endtask

    // ------------------------------------------------------------------
    // offer one sample; the expectation is queued at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic ch,
                             input logic known, input logic [SAMPLE_W-1:0] want);
        int                  gap;
        logic [SAMPLE_W-1:0] predicted;
        t_result             entry;
        gap = quiet_tx ? 0 : $urandom_range(0, 15);
        // valid only drops when a gap is drawn, so back-to-back items stay high
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sample;
        i_s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted     = filter_sample(sample, ch);
        entry.sample  = known ? want : predicted;
        entry.channel = ch;
        pending_results.push_back(entry);
    endtask

    // ------------------------------------------------------------------
    // result sink: random stalls, plus one long hold when asked
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_len > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            stall = quiet_rx ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // scoreboard: each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want_item;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending",
                                32'(o_m_axis_tdata), 32'd0);
            end else begin
                want_item = pending_results.pop_front();
                if (o_m_axis_tdata[SAMPLE_W-1:0] !== want_item.sample)
                    report_mismatch("sample_out", 32'(o_m_axis_tdata),
                                    32'(want_item.sample));
                if (o_m_axis_tuser !== want_item.channel)
                    report_mismatch("channel_out", 32'(o_m_axis_tuser),
                                    32'(want_item.channel));
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0]         rnd;
        logic [SAMPLE_W-1:0] sample;
        logic                ch;
        logic [COEF_W-1:0]   b0;
        logic [COEF_W-1:0]   a1;
        logic [COEF_W-1:0]   a2;
        int                  a1_mag;
        int                  a2_val;
        int                  pick;
        bit                  bypass_phase;

        // synchronous reset held low from time zero, then released
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].addr, directed_rows[r].value);
            else
                send_item(directed_rows[r].value, directed_rows[r].ch,
                          directed_rows[r].known, directed_rows[r].want);
        end

        // random phases, each with its own coefficient set
        ch = 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0, 3: begin
                    // stable low-pass region: 0.5 <= a2 < 0.95, |a1| < 1 + a2
                    a2_val = $urandom_range(2097152, 3984588);
                    a1_mag = $urandom_range(0, 4194304 + a2_val - 1);
                    rnd = -a1_mag;
                    a1  = rnd[COEF_W-1:0];
                    rnd = a2_val;
                    a2  = rnd[COEF_W-1:0];
                    rnd = $urandom_range(1, 1 << 20);
                    b0  = rnd[COEF_W-1:0];
                end
                1: begin
                    // anything goes, unstable sets included
                    rnd = $urandom; b0 = rnd[COEF_W-1:0];
                    rnd = $urandom; a1 = rnd[COEF_W-1:0];
                    rnd = $urandom; a2 = rnd[COEF_W-1:0];
                end
                default: begin
                    b0 = corner_pick();
                    a1 = corner_pick();
                    a2 = corner_pick();
                end
            endcase
            bypass_phase = (phase == 7) || ($urandom_range(0, 5) == 0);

            write_reg(sbq_pkg::REG_B0, b0);
            write_reg(sbq_pkg::REG_A1, a1);
            write_reg(sbq_pkg::REG_A2, a2);
            rnd = $urandom;
            write_reg(sbq_pkg::REG_BYPASS, {rnd[COEF_W-1:1], bypass_phase});

            // phase 2 holds the sink off long enough to back up the input;
            // phase 4 runs with no idling on either side
            quiet_tx = (phase == 2) || (phase == 4);
            quiet_rx = (phase == 4);
            if (phase == 2) rx_hold_len = HOLD_CYCLES;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // flip bypass mid-phase now and then; delays must survive it
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 3) == 0) begin
                    rnd = $urandom;
                    write_reg(sbq_pkg::REG_BYPASS, {rnd[COEF_W-1:1], ~bypass_on});
                end
                pick = $urandom_range(0, 19);
                rnd  = $urandom;
                if (pick < 12) begin
                    sample = rnd[SAMPLE_W-1:0];
                end else if (pick < 16) begin
                    rnd    = $urandom_range(0, 2047) - 1024;
                    sample = rnd[SAMPLE_W-1:0];
                end else begin
                    sample = corner_pick();
                end
                // mostly interleaved stereo, sometimes runs on one channel
                if ($urandom_range(0, 9) < 7)
                    ch = ~ch;
                else
                    ch = ($urandom_range(0, 1) != 0);
                send_item(sample, ch, 1'b0, '0);
            end
        end

        // drain and close
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
